// ===== rtl/core/f2g_pkg.sv =====
// f2g_pkg: shared constants for the fp32 to 16-bit packing pipeline.
// No dependencies.
package f2g_pkg;

	localparam logic [31:0] FP_INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
	localparam logic [31:0] FP_EXP_ONE   = 32'h0080_0000;
	localparam logic [7:0]  FP_EXP_MAX   = 8'hFF;
	localparam logic [7:0]  FP_EXP_TOP   = 8'hFE;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BF16_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SH  = 2'd2;

	localparam logic [31:0] RST_MIN_NORM = 32'h3880_0000;
	localparam logic [4:0]  RST_ALIGN_SH = 5'd13;

endpackage

// ===== rtl/core/f2g_fpadd.sv =====
// f2g_fpadd: two-stage single-precision add of two non-negative, non-NaN
// operands with a <= b, round to nearest even. Depends on f2g_pkg.
module f2g_fpadd (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum_s2
);
	import f2g_pkg::*;

	logic [7:0]  ea, eb, exa, exb, ediff;
	logic [5:0]  dsh;
	logic [23:0] siga, sigb;
	logic [73:0] wide;

	logic [25:0] align_s1;
	logic        stk_s1;
	logic [23:0] sigb_s1;
	logic [7:0]  exb_s1;
	logic        binf_s1;

	logic [26:0] add;
	logic [23:0] mant;
	logic        g, st, inc;
	logic [8:0]  e;
	logic [31:0] bits;

	// stage 1: align the smaller operand, keep guard/round/sticky
	always_comb begin
		ea    = a[30:23];
		eb    = b[30:23];
		exa   = (ea == 8'd0) ? 8'd1 : ea;
		exb   = (eb == 8'd0) ? 8'd1 : eb;
		siga  = {ea != 8'd0, a[22:0]};
		sigb  = {eb != 8'd0, b[22:0]};
		ediff = exb - exa;
		dsh   = (ediff > 8'd50) ? 6'd50 : ediff[5:0];
		wide  = {siga, 50'd0} >> dsh;
	end

	always_ff @(posedge clk) begin
		align_s1 <= wide[73:48];
		stk_s1   <= |wide[47:0];
		sigb_s1  <= sigb;
		exb_s1   <= exb;
		binf_s1  <= (eb == FP_EXP_MAX);
	end

	// stage 2: add, normalize on carry, round; overflow saturates to infinity
	always_comb begin
		add = {1'b0, sigb_s1, 2'b00} + {1'b0, align_s1};
		if (add[26]) begin
			mant = add[26:3];
			g    = add[2];
			st   = (|add[1:0]) | stk_s1;
			e    = {1'b0, exb_s1} + 9'd1;
		end else begin
			mant = add[25:2];
			g    = add[1];
			st   = add[0] | stk_s1;
			e    = {1'b0, exb_s1};
		end
		inc  = g & (st | mant[0]);
		bits = {e[7:0] - 8'd1, 23'd0} + {8'd0, mant} + {31'd0, inc};
	end

	always_ff @(posedge clk) begin
		sum_s2 <= (binf_s1 || e >= 9'd255) ? FP_INF_BITS : bits;
	end

endmodule

// ===== rtl/core/fp32_to_gf16_pack_top.sv =====
// fp32_to_gf16_pack_top: converts one fp32 word per cycle to a 16-bit packed
// word. Depends on f2g_pkg and f2g_fpadd.
//
// Usage:
//  - Input: drive value_bits and pulse start; a transaction is taken at each
//    clock edge with start high and busy low. busy is always low, so a new
//    item can enter every cycle.
//  - Output: packed_bits is valid for the single cycle in which done is high.
//    The receiver cannot stall; results are never held back.
//  - Accept-to-done path: vld_s1, vld_s2, vld_s3 (done); throughput is one item per
//    cycle. The depth is set by the add path: align (stage 1), add/round
//    (stage 2), rebase/shift/mask (stage 3).
//  - Config: cfg_valid/cfg_ready (ready always high) with cfg_index and
//    cfg_data. Index 0 bf16_mode, 1 min_norm_bits, 2 align_shift; other
//    indexes are ignored. Write only while no transaction is in flight.
//  - Reset (arst_n low, asynchronous) clears the pipeline valid bits and
//    loads bf16_mode=0, min_norm_bits=0x38800000, align_shift=13.
//  - bf16 mode: upper 16 bits of the input, truncated.
//  - General mode: magnitude below min normal gets it added (RNE), else is
//    doubled (a NaN is quieted instead); then min normal bits are subtracted,
//    shifted, masked to 15 bits, with the sign in bit 15.
module fp32_to_gf16_pack_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [31:0]                    value_bits,
	output logic                           done,
	output logic [15:0]                    packed_bits,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [f2g_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import f2g_pkg::*;

	// config registers
	logic        bf16_mode_q;
	logic [31:0] min_norm_q;
	logic [4:0]  align_sh_q;

	// stage 0 decode
	logic        sgn;
	logic [31:0] mag, dbl, alt;
	logic        mag_nan, nb_nan, sel_add;

	// pipeline
	logic        vld_s1, vld_s2, vld_s3;
	logic        sgn_s1, sgn_s2;
	logic        sel_s1, sel_s2;
	logic        bf_s1, bf_s2;
	logic [15:0] hi_s1, hi_s2;
	logic [31:0] alt_s1, alt_s2;
	logic [31:0] add_s2;
	logic [31:0] conv, word, shr;
	logic [15:0] pack_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf16_mode_q <= 1'b0;
			min_norm_q  <= RST_MIN_NORM;
			align_sh_q  <= RST_ALIGN_SH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BF16_MODE: bf16_mode_q <= cfg_data[0];
				CFG_MIN_NORM:  min_norm_q  <= cfg_data;
				CFG_ALIGN_SH:  align_sh_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Add path only for a non-NaN, non-negative min normal above the
	// magnitude; both are then non-negative so the float compare is an
	// unsigned compare of the bits. Doubling is exact unless it overflows to infinity.
	always_comb begin
		sgn     = value_bits[31];
		mag     = {1'b0, value_bits[30:0]};
		mag_nan = (mag[30:23] == FP_EXP_MAX) && (mag[22:0] != 23'd0);
		nb_nan  = (min_norm_q[30:23] == FP_EXP_MAX) && (min_norm_q[22:0] != 23'd0);
		sel_add = !min_norm_q[31] && !nb_nan && (mag < min_norm_q);
		if (mag[30:23] == 8'd0)
			dbl = mag << 1;
		else if (mag[30:23] >= FP_EXP_TOP)
			dbl = FP_INF_BITS;
		else
			dbl = mag + FP_EXP_ONE;
		alt = mag_nan ? (mag | FP_QUIET_BIT) : dbl;
	end

	f2g_fpadd u_add (
		.clk    (clk),
		.a      (mag),
		.b      (min_norm_q),
		.sum_s2 (add_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1 <= sgn;
		sel_s1 <= sel_add;
		bf_s1  <= bf16_mode_q;
		hi_s1  <= value_bits[31:16];
		alt_s1 <= alt;
		sgn_s2 <= sgn_s1;
		sel_s2 <= sel_s1;
		bf_s2  <= bf_s1;
		hi_s2  <= hi_s1;
		alt_s2 <= alt_s1;
	end

	// stage 3: rebase on min normal bits, align, mask; sign goes to bit 15
	always_comb begin
		conv = (sel_s2 ? add_s2 : alt_s2) | {sgn_s2, 31'd0};
		word = conv - min_norm_q;
		shr  = word >> align_sh_q;
	end

	always_ff @(posedge clk) begin
		pack_s3 <= bf_s2 ? hi_s2 : {sgn_s2, shr[14:0]};
	end

	assign done        = vld_s3;
	assign packed_bits = pack_s3;

endmodule

// ===== rtl/core/f2g_chk.sv =====
// f2g_chk: port-level checker for fp32_to_gf16_pack_top, bound to it below.
// Depends on f2g_pkg.
module f2g_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [f2g_pkg::CFG_IDX_W-1:0] cfg_index
);
	import f2g_pkg::*;

	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted transaction produced no result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##3 !done)
		else $error("result without an accepted transaction");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("pipeline reported busy");

	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index != CFG_BF16_MODE) |-> !done)
		else $error("config write while a result is being delivered");

endmodule

bind fp32_to_gf16_pack_top f2g_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);
